@@ rtl/rpkd_pkg.sv @@
package rpkd_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int TIME_BITS    = 32;
   localparam int CH_BITS      = 4;
   localparam int ROM_SIZE     = 54;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [7:0] HEADER_VALUE = 8'h14;

   typedef enum logic [2:0] {
      K_NONE = 3'd0,
      K_LIT  = 3'd1,
      K_ACC  = 3'd2,
      K_LU   = 3'd3,
      K_RU   = 3'd4,
      K_LD   = 3'd5,
      K_RD   = 3'd6,
      K_FIL  = 3'd7
   } key_kind_type;

   typedef enum logic [1:0] {
      EV_KEY    = 2'd0,
      EV_MOTION = 2'd1,
      EV_SYNC   = 2'd2
   } event_kind_type;

   typedef struct packed {
      key_kind_type kind;
      logic [7:0]   b1;
      logic [7:0]   b2;
      logic         axis;
      logic         neg;
   } rom_entry_type;

   // classified packet handed from the front to the back
   typedef struct packed {
      logic [CH_BITS-1:0] channel;
      logic               sync_only;
      key_kind_type       kind;
      logic [5:0]         index;
      logic               axis;
      logic               neg;
      logic               lit_value;
      logic [3:0]         accel;
   } job_type;

   function automatic rom_entry_type rom_entry(input logic [5:0] i);
      rom_entry_type e;
      e = '{K_NONE, 8'h00, 8'h00, 1'b0, 1'b0};
      case (i)
         6'd0:  e = '{K_LIT, 8'h3d, 8'h78, 1'b0, 1'b0};
         6'd1:  e = '{K_LIT, 8'h3e, 8'h79, 1'b0, 1'b0};
         6'd2:  e = '{K_LIT, 8'h41, 8'h7c, 1'b0, 1'b0};
         6'd3:  e = '{K_LIT, 8'h42, 8'h7d, 1'b0, 1'b0};
         6'd4:  e = '{K_ACC, 8'h35, 8'h70, 1'b0, 1'b1};
         6'd5:  e = '{K_ACC, 8'h36, 8'h71, 1'b0, 1'b0};
         6'd6:  e = '{K_ACC, 8'h37, 8'h72, 1'b1, 1'b1};
         6'd7:  e = '{K_ACC, 8'h38, 8'h73, 1'b1, 1'b0};
         6'd8:  e = '{K_LU,  8'h39, 8'h74, 1'b0, 1'b0};
         6'd9:  e = '{K_RU,  8'h3a, 8'h75, 1'b0, 1'b0};
         6'd10: e = '{K_LD,  8'h3c, 8'h77, 1'b0, 1'b0};
         6'd11: e = '{K_RD,  8'h3b, 8'h76, 1'b0, 1'b0};
         6'd12: e = '{K_FIL, 8'he2, 8'h1d, 1'b0, 1'b0};
         6'd13: e = '{K_FIL, 8'he4, 8'h1f, 1'b0, 1'b0};
         6'd14: e = '{K_FIL, 8'he7, 8'h22, 1'b0, 1'b0};
         6'd15: e = '{K_FIL, 8'hdf, 8'h1a, 1'b0, 1'b0};
         6'd16: e = '{K_FIL, 8'he3, 8'h1e, 1'b0, 1'b0};
         6'd17: e = '{K_FIL, 8'hd2, 8'h0d, 1'b0, 1'b0};
         6'd18: e = '{K_FIL, 8'hd3, 8'h0e, 1'b0, 1'b0};
         6'd19: e = '{K_FIL, 8'hd4, 8'h0f, 1'b0, 1'b0};
         6'd20: e = '{K_FIL, 8'hd5, 8'h10, 1'b0, 1'b0};
         6'd21: e = '{K_FIL, 8'hd6, 8'h11, 1'b0, 1'b0};
         6'd22: e = '{K_FIL, 8'hd7, 8'h12, 1'b0, 1'b0};
         6'd23: e = '{K_FIL, 8'hd8, 8'h13, 1'b0, 1'b0};
         6'd24: e = '{K_FIL, 8'hd9, 8'h14, 1'b0, 1'b0};
         6'd25: e = '{K_FIL, 8'hda, 8'h15, 1'b0, 1'b0};
         6'd26: e = '{K_FIL, 8'hdc, 8'h17, 1'b0, 1'b0};
         6'd27: e = '{K_FIL, 8'hdd, 8'h18, 1'b0, 1'b0};
         6'd28: e = '{K_FIL, 8'hc5, 8'h00, 1'b0, 1'b0};
         6'd29: e = '{K_FIL, 8'hc6, 8'h01, 1'b0, 1'b0};
         6'd30: e = '{K_FIL, 8'hde, 8'h19, 1'b0, 1'b0};
         6'd31: e = '{K_FIL, 8'he0, 8'h1b, 1'b0, 1'b0};
         6'd32: e = '{K_FIL, 8'he6, 8'h21, 1'b0, 1'b0};
         6'd33: e = '{K_FIL, 8'he8, 8'h23, 1'b0, 1'b0};
         6'd34: e = '{K_FIL, 8'hdb, 8'h16, 1'b0, 1'b0};
         6'd35: e = '{K_FIL, 8'hc7, 8'h02, 1'b0, 1'b0};
         6'd36: e = '{K_FIL, 8'hc8, 8'h03, 1'b0, 1'b0};
         6'd37: e = '{K_FIL, 8'hc9, 8'h04, 1'b0, 1'b0};
         6'd38: e = '{K_FIL, 8'hca, 8'h05, 1'b0, 1'b0};
         6'd39: e = '{K_FIL, 8'hcb, 8'h06, 1'b0, 1'b0};
         6'd40: e = '{K_FIL, 8'hcc, 8'h07, 1'b0, 1'b0};
         6'd41: e = '{K_FIL, 8'he1, 8'h1c, 1'b0, 1'b0};
         6'd42: e = '{K_FIL, 8'hce, 8'h09, 1'b0, 1'b0};
         6'd43: e = '{K_FIL, 8'hcd, 8'h08, 1'b0, 1'b0};
         6'd44: e = '{K_FIL, 8'hcf, 8'h0a, 1'b0, 1'b0};
         6'd45: e = '{K_FIL, 8'hd1, 8'h0c, 1'b0, 1'b0};
         6'd46: e = '{K_FIL, 8'hd0, 8'h0b, 1'b0, 1'b0};
         6'd47: e = '{K_FIL, 8'hec, 8'h27, 1'b0, 1'b0};
         6'd48: e = '{K_FIL, 8'hea, 8'h25, 1'b0, 1'b0};
         6'd49: e = '{K_FIL, 8'he9, 8'h24, 1'b0, 1'b0};
         6'd50: e = '{K_FIL, 8'heb, 8'h26, 1'b0, 1'b0};
         6'd51: e = '{K_FIL, 8'hed, 8'h28, 1'b0, 1'b0};
         6'd52: e = '{K_FIL, 8'hee, 8'h29, 1'b0, 1'b0};
         6'd53: e = '{K_FIL, 8'he5, 8'h20, 1'b0, 1'b0};
         default: e = '{K_NONE, 8'h00, 8'h00, 1'b0, 1'b0};
      endcase
      return e;
   endfunction

   // a is later than b, modulo the timestamp width
   function automatic logic later(input logic [TIME_BITS-1:0] a,
                                  input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] d;
      d = a - b;
      return (d != '0) && !d[TIME_BITS-1];
   endfunction

endpackage

@@ rtl/rpkd_front.sv @@
module rpkd_front
   import rpkd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [3:0]           req_packet_length,
   input  logic [7:0]           req_header_byte,
   input  logic [7:0]           req_key_byte_a,
   input  logic [7:0]           req_key_byte_b,
   input  logic [7:0]           req_channel_byte,
   input  logic [31:0]          req_now_ticks,
   input  logic [15:0]          ignore_channels,
   input  logic [15:0]          ticks_per_second,
   output logic                 job_valid,
   input  logic                 job_stall,
   output job_type              job
);

   // stage 1: captured packet, ROM match and time offsets
   logic                   s1_valid_ff, s1_valid_in;
   logic [CH_BITS-1:0]     s1_ch_ff;
   logic                   s1_sync_ff, s1_drop_ff, s1_bad_ff;
   logic [15:0]            s1_key_ff;
   logic [TIME_BITS-1:0]   s1_now_ff;
   logic [5:0]             s1_idx_ff, s1_idx_in;
   logic                   s1_hit_ff, s1_hit_in;
   logic [TIME_BITS-1:0]   s1_hz1_ff, s1_hz2_ff, s1_hz3_ff, s1_hz4_ff, s1_hzh_ff, s1_hzq_ff;

   logic [15:0]            key_code_ff [NUM_CHANNELS];
   logic [TIME_BITS-1:0]   key_time_ff [NUM_CHANNELS];

   logic                   out_valid_ff;
   job_type                out_ff, out_in;
   logic                   adv1, adv2;
   logic [3:0]             ch_raw;
   logic                   ch_drop;
   logic                   same;
   logic [TIME_BITS-1:0]   t_last;
   logic [3:0]             accel;
   rom_entry_type          e;
   logic                   repeat_hit;
   logic                   commit;

   assign adv2      = s1_valid_ff && (!out_valid_ff || !job_stall);
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;
   assign job_valid = out_valid_ff;
   assign job       = out_ff;

   assign ch_raw  = req_channel_byte[7:4];
   assign ch_drop = (32'(ch_raw) >= NUM_CHANNELS) || ignore_channels[ch_raw];

   always_comb begin
      rom_entry_type r;
      logic [3:0]    hn;
      s1_idx_in = '0;
      s1_hit_in = 1'b0;
      for (int i = ROM_SIZE - 1; i >= 0; i--) begin
         r  = rom_entry(6'(i));
         hn = r.b1[7:4] - req_key_byte_a[7:4] + ch_raw;
         if (r.b1[3:0] == req_key_byte_a[3:0] && hn == 4'hf && r.b2 == req_key_byte_b) begin
            s1_idx_in = 6'(i);
            s1_hit_in = 1'b1;
         end
      end
   end

   assign s1_valid_in = adv1 ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (adv2) out_valid_ff <= !(s1_drop_ff || (!s1_sync_ff && !s1_bad_ff && repeat_hit));
         else if (!job_stall) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ch_ff   <= (req_packet_length != 4'd4) ? 4'hf : ch_raw;
         s1_sync_ff <= req_packet_length != 4'd4;
         s1_drop_ff <= (req_packet_length == 4'd4) && ch_drop;
         s1_bad_ff  <= req_header_byte != HEADER_VALUE || req_channel_byte[3:0] != 4'h0;
         s1_key_ff  <= {req_key_byte_a, req_key_byte_b};
         s1_now_ff  <= TIME_BITS'(req_now_ticks);
         s1_idx_ff  <= s1_idx_in;
         s1_hit_ff  <= s1_hit_in;
         s1_hz1_ff  <= TIME_BITS'(ticks_per_second);
         s1_hz2_ff  <= TIME_BITS'({ticks_per_second, 1'b0});
         s1_hz3_ff  <= TIME_BITS'({ticks_per_second, 1'b0}) + TIME_BITS'(ticks_per_second);
         s1_hz4_ff  <= TIME_BITS'({ticks_per_second, 2'b0});
         s1_hzh_ff  <= TIME_BITS'(ticks_per_second[15:1]);
         s1_hzq_ff  <= TIME_BITS'(ticks_per_second[15:2]);
      end
      if (adv2) out_ff <= out_in;
   end

   assign same   = key_code_ff[s1_ch_ff] == s1_key_ff;
   assign t_last = key_time_ff[s1_ch_ff];
   assign e      = rom_entry(s1_idx_ff);

   always_comb begin
      accel = 4'd1;
      if (same) begin
         if (later(s1_now_ff, t_last + s1_hz4_ff))      accel = 4'd8;
         else if (later(s1_now_ff, t_last + s1_hz3_ff)) accel = 4'd6;
         else if (later(s1_now_ff, t_last + s1_hz2_ff)) accel = 4'd4;
         else if (later(s1_now_ff, t_last + s1_hz1_ff)) accel = 4'd3;
         else if (later(s1_now_ff, t_last + s1_hzh_ff)) accel = 4'd2;
      end
   end

   assign repeat_hit = s1_hit_ff && e.kind == K_FIL && same &&
                       later(t_last + s1_hzq_ff, s1_now_ff);
   assign commit = adv2 && !s1_sync_ff && !s1_drop_ff && !s1_bad_ff && !repeat_hit;

   always_comb begin
      out_in.channel   = s1_ch_ff;
      out_in.sync_only = s1_sync_ff || s1_bad_ff || !s1_hit_ff;
      out_in.kind      = s1_hit_ff ? e.kind : K_NONE;
      out_in.index     = s1_idx_ff;
      out_in.axis      = e.axis;
      out_in.neg       = e.neg;
      out_in.lit_value = s1_idx_ff == 6'd0 || s1_idx_ff == 6'd2;
      out_in.accel     = accel;
   end

   // update per-channel key history
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            key_code_ff[i] <= '0;
            key_time_ff[i] <= '0;
         end
      end else if (commit) begin
         key_code_ff[s1_ch_ff] <= s1_key_ff;
         if (!same || (s1_hit_ff && e.kind == K_FIL)) key_time_ff[s1_ch_ff] <= s1_now_ff;
      end
   end

endmodule

@@ rtl/rpkd_queue.sv @@
module rpkd_queue
   import rpkd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_stall,
   output job_type out_job
);

   job_type    mem_ff [QUEUE_DEPTH];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = cnt_ff == 2'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != 2'd0;
   assign out_job   = mem_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_job;
   end

endmodule

@@ rtl/rpkd_back.sv @@
module rpkd_back
   import rpkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_stall,
   input  job_type     job,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_channel,
   output logic [1:0]  rsp_event_kind,
   output logic [5:0]  rsp_event_code,
   output logic signed [4:0] rsp_event_value,
   output logic        rsp_last_of_run
);

   logic [1:0]        step_ff, step_in;
   logic [1:0]        count;
   logic              last;
   logic              take;
   logic              vld_ff;
   logic [3:0]        ch_ff;
   logic [1:0]        kind_ff, kind_in;
   logic [5:0]        code_ff, code_in;
   logic signed [4:0] val_ff, val_in;
   logic              last_ff;
   logic signed [4:0] pos, negv;

   always_comb begin
      case (job.kind)
         K_LU, K_RU, K_LD, K_RD: count = 2'd3;
         K_LIT, K_ACC:           count = 2'd2;
         K_FIL:                  count = 2'd3;
         default:                count = 2'd1;
      endcase
      if (job.sync_only) count = 2'd1;
   end

   assign take      = job_valid && (!vld_ff || !rsp_stall);
   assign last      = step_ff == count - 2'd1;
   assign job_stall = !(take && last);
   assign step_in   = take ? (last ? 2'd0 : step_ff + 2'd1) : step_ff;
   assign pos       = 5'(job.accel);
   assign negv      = -pos;

   always_comb begin
      kind_in = EV_SYNC;
      code_in = '0;
      val_in  = '0;
      if (!last) begin
         case (job.kind)
            K_LIT: begin
               kind_in = EV_KEY; code_in = job.index; val_in = 5'(job.lit_value);
            end
            K_ACC: begin
               kind_in = EV_MOTION; code_in = 6'(job.axis); val_in = job.neg ? negv : pos;
            end
            K_FIL: begin
               kind_in = EV_KEY; code_in = job.index; val_in = (step_ff == 2'd0) ? 5'sd1 : 5'sd0;
            end
            K_LU, K_RU, K_LD, K_RD: begin
               kind_in = EV_MOTION;
               code_in = 6'(step_ff);
               if (step_ff == 2'd0)
                  val_in = (job.kind == K_LU || job.kind == K_LD) ? negv : pos;
               else
                  val_in = (job.kind == K_LU || job.kind == K_RU) ? negv : pos;
            end
            default: begin
               kind_in = EV_SYNC;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (take) vld_ff <= 1'b1;
         else if (!rsp_stall) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ch_ff   <= job.channel;
         kind_ff <= kind_in;
         code_ff <= code_in;
         val_ff  <= val_in;
         last_ff <= last;
      end
   end

   assign rsp_valid       = vld_ff;
   assign rsp_channel     = ch_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_event_code  = code_ff;
   assign rsp_event_value = val_ff;
   assign rsp_last_of_run = last_ff;

endmodule

@@ rtl/remote_packet_key_decoder_unit.sv @@
// channel  ports                                   direction
// req      req_valid/req_stall, packet fields      in
// rsp      rsp_valid/rsp_stall, event fields       out
// csr      csr_write/csr_index/csr_data            in
// A packet can enter each cycle while req_stall is low; the front classifies it
// in its stage-1 register and its output register. The back emits one word a cycle
// unless rsp is stalled, up to three words per packet, so the output port sets the rate.
// Synchronous reset clears channel history, queue and registers.
// A two-entry queue lets the front keep working while rsp is stalled.
module remote_packet_key_decoder_unit
   import rpkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_packet_length,
   input  logic [7:0]  req_header_byte,
   input  logic [7:0]  req_key_byte_a,
   input  logic [7:0]  req_key_byte_b,
   input  logic [7:0]  req_channel_byte,
   input  logic [31:0] req_now_ticks,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_channel,
   output logic [1:0]  rsp_event_kind,
   output logic [5:0]  rsp_event_code,
   output logic signed [4:0] rsp_event_value,
   output logic        rsp_last_of_run,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] ignore_ff;
   logic [15:0] hz_ff;
   logic        fj_valid, fj_stall, bj_valid, bj_stall;
   job_type     fj, bj;

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff <= '0;
         hz_ff     <= 16'd1000;
      end else if (csr_write) begin
         if (csr_index == 1'b0) ignore_ff <= csr_data;
         else hz_ff <= csr_data;
      end
   end

   rpkd_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_packet_length, .req_header_byte,
      .req_key_byte_a, .req_key_byte_b, .req_channel_byte, .req_now_ticks,
      .ignore_channels(ignore_ff), .ticks_per_second(hz_ff),
      .job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
   );

   rpkd_queue u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_stall(fj_stall), .in_job(fj),
      .out_valid(bj_valid), .out_stall(bj_stall), .out_job(bj)
   );

   rpkd_back u_back (
      .clock, .reset, .job_valid(bj_valid), .job_stall(bj_stall), .job(bj),
      .rsp_valid, .rsp_stall, .rsp_channel, .rsp_event_kind, .rsp_event_code,
      .rsp_event_value, .rsp_last_of_run
   );

endmodule

@@ tb/sv/rpkd_checker.sv @@
module rpkd_checker
   import rpkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [3:0]  req_packet_length,
   input  logic [7:0]  req_header_byte,
   input  logic [7:0]  req_key_byte_a,
   input  logic [7:0]  req_key_byte_b,
   input  logic [7:0]  req_channel_byte,
   input  logic [31:0] req_now_ticks,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_channel,
   input  logic [1:0]  rsp_event_kind,
   input  logic [5:0]  rsp_event_code,
   input  logic signed [4:0] rsp_event_value,
   input  logic        rsp_last_of_run,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending_events
);

   typedef struct packed {
      logic [3:0]        channel;
      event_kind_type    kind;
      logic [5:0]        code;
      logic signed [4:0] value;
      logic              last;
   } event_word_type;

   event_word_type event_fifo[$];
   logic [15:0] mask_reg;
   logic [15:0] hz_reg;
   logic [15:0] key_hist[16];
   logic [31:0] time_hist[16];

   assign pending_events = event_fifo.size();

   function automatic event_word_type mk(input logic [3:0] ch, input event_kind_type k,
                                         input logic [5:0] c, input int v, input logic l);
      event_word_type w;
      w.channel = ch;
      w.kind = k;
      w.code = c;
      w.value = 5'(v);
      w.last = l;
      return w;
   endfunction

   function automatic bit is_later(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d != 0 && !d[31];
   endfunction

   task automatic decode_packet(input logic [3:0] len, input logic [7:0] hdr,
                                input logic [7:0] ka, input logic [7:0] kb,
                                input logic [7:0] cb, input logic [31:0] now);
      logic [3:0] ch;
      logic [15:0] key;
      logic [31:0] t, hz;
      bit same;
      int accel, i, hit;
      rom_entry_type e;
      accel = 1;
      hit = -1;
      hz = {16'd0, hz_reg};
      if (len != 4) begin
         event_fifo.push_back(mk(4'hf, EV_SYNC, 0, 0, 1));
         return;
      end
      ch = cb[7:4];
      if (mask_reg[ch]) return;
      if (hdr != HEADER_VALUE || cb[3:0] != 0) begin
         event_fifo.push_back(mk(ch, EV_SYNC, 0, 0, 1));
         return;
      end
      key = {ka, kb};
      same = key_hist[ch] == key;
      t = time_hist[ch];
      if (same) begin
         if (is_later(now, t + 4 * hz)) accel = 8;
         else if (is_later(now, t + 3 * hz)) accel = 6;
         else if (is_later(now, t + 2 * hz)) accel = 4;
         else if (is_later(now, t + hz)) accel = 3;
         else if (is_later(now, t + (hz >> 1))) accel = 2;
      end
      for (i = 0; i < ROM_SIZE && hit < 0; i++) begin
         e = rom_entry(6'(i));
         if (e.b1[3:0] == ka[3:0] && 4'(e.b1[7:4] - ka[7:4] + ch) == 4'hf && e.b2 == kb)
            hit = i;
      end
      if (hit >= 0) begin
         e = rom_entry(6'(hit));
         case (e.kind)
            K_LIT: event_fifo.push_back(mk(ch, EV_KEY, 6'(hit), hit == 0 || hit == 2, 0));
            K_ACC: event_fifo.push_back(mk(ch, EV_MOTION, e.axis, e.neg ? -accel : accel, 0));
            K_LU, K_RU, K_LD, K_RD: begin
               event_fifo.push_back(mk(ch, EV_MOTION, 0,
                  (e.kind == K_LU || e.kind == K_LD) ? -accel : accel, 0));
               event_fifo.push_back(mk(ch, EV_MOTION, 1,
                  (e.kind == K_LU || e.kind == K_RU) ? -accel : accel, 0));
            end
            default: begin
               // drop a repeat inside the debounce window
               if (same && is_later(t + (hz >> 2), now)) return;
               event_fifo.push_back(mk(ch, EV_KEY, 6'(hit), 1, 0));
               event_fifo.push_back(mk(ch, EV_KEY, 6'(hit), 0, 0));
               time_hist[ch] = now;
            end
         endcase
      end
      if (!same) time_hist[ch] = now;
      key_hist[ch] = key;
      event_fifo.push_back(mk(ch, EV_SYNC, 0, 0, 1));
   endtask

   always @(posedge clock) begin
      event_word_type got, want;
      if (reset) begin
         mask_reg <= 16'd0;
         hz_reg <= 16'd1000;
         for (int k = 0; k < 16; k++) begin
            key_hist[k] = 0;
            time_hist[k] = 0;
         end
         event_fifo.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index) hz_reg <= csr_data;
            else mask_reg <= csr_data;
         end
         if (req_valid && !req_stall)
            decode_packet(req_packet_length, req_header_byte, req_key_byte_a,
                          req_key_byte_b, req_channel_byte, req_now_ticks);
         if (rsp_valid && !rsp_stall) begin
            got = mk(rsp_channel, event_kind_type'(rsp_event_kind), rsp_event_code,
                     rsp_event_value, rsp_last_of_run);
            if (event_fifo.size() == 0) begin
               if (fail_count < 10) $display("unexpected word %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = event_fifo.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"mismatch: expected ch %0d kind %0d code %0d val %0d last %0d,",
                               " got ch %0d kind %0d code %0d val %0d last %0d"},
                        want.channel, want.kind, want.code, want.value, want.last,
                        got.channel, got.kind, got.code, got.value, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ tb/sv/tb_remote_packet_key_decoder_unit.sv @@
module tb_remote_packet_key_decoder_unit;
   import rpkd_pkg::*;

   localparam logic CSR_MASK = 1'b0;
   localparam logic CSR_HZ   = 1'b1;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [3:0] req_packet_length = 0;
   logic [7:0] req_header_byte = 0, req_key_byte_a = 0, req_key_byte_b = 0;
   logic [7:0] req_channel_byte = 0;
   logic [31:0] req_now_ticks = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [3:0] rsp_channel;
   logic [1:0] rsp_event_kind;
   logic [5:0] rsp_event_code;
   logic signed [4:0] rsp_event_value;
   logic rsp_last_of_run;
   logic csr_write = 0, csr_index = 0;
   logic [15:0] csr_data = 0;
   int fail_count, pending_events;
   bit calm = 0;
   logic [31:0] clock_ticks = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   remote_packet_key_decoder_unit dut (.*);
   rpkd_checker chk (.*);

   // output-side stall bursts
   initial begin
      int n;
      wait (!reset);
      forever begin
         n = $urandom_range(1, 16);
         @(posedge clock) rsp_stall <= !calm && ($urandom_range(0, 2) == 0);
         repeat (n - 1) @(posedge clock);
      end
   end

   // valid stays high between back-to-back words; drop it only for an idle burst
   task automatic drive_req(input logic [3:0] len, input logic [7:0] hdr,
                            input logic [7:0] ka, input logic [7:0] kb,
                            input logic [7:0] cb, input logic [31:0] now);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1;
      req_packet_length <= len;
      req_header_byte <= hdr;
      req_key_byte_a <= ka;
      req_key_byte_b <= kb;
      req_channel_byte <= cb;
      req_now_ticks <= now;
      do @(posedge clock); while (req_stall);
   endtask

   // valid packet for a ROM entry on a channel
   task automatic send_key(input int idx, input logic [3:0] ch, input logic [31:0] now);
      rom_entry_type e;
      logic [7:0] ka;
      e = rom_entry(6'(idx));
      ka = {4'(e.b1[7:4] + ch + 4'd1), e.b1[3:0]};
      drive_req(4, HEADER_VALUE, ka, e.b2, {ch, 4'h0}, now);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] val);
      req_valid <= 0;
      @(posedge clock);
      while (pending_events != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic random_phase(input int count);
      int idx;
      logic [3:0] ch;
      for (int i = 0; i < count; i++) begin
         clock_ticks = clock_ticks + $urandom_range(0, 3000);
         ch = 4'($urandom_range(0, 15));
         case ($urandom_range(0, 9))
            0: drive_req(4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), $urandom);
            1: drive_req(4, HEADER_VALUE, 8'($urandom), 8'($urandom), {ch, 4'h0},
                         clock_ticks);
            default: begin
               idx = ($urandom_range(0, 1)) ? $urandom_range(4, 11) : $urandom_range(0, 53);
               send_key(idx, ch, clock_ticks);
               // hold the key a while to build up acceleration and repeats
               repeat ($urandom_range(0, 3)) begin
                  clock_ticks = clock_ticks + $urandom_range(0, 1500);
                  send_key(idx, ch, clock_ticks);
               end
            end
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      drive_req(0, 0, 0, 0, 0, 0);
      drive_req(15, 8'hff, 8'hff, 8'hff, 8'hff, 32'hffffffff);
      drive_req(4, 8'h15, 8'h3d, 8'h78, 8'h30, 10);
      drive_req(4, HEADER_VALUE, 8'h3d, 8'h78, 8'h35, 10);
      drive_req(4, HEADER_VALUE, 8'h00, 8'h00, 8'h20, 10);
      for (int k = 0; k < 12; k++) send_key(k, 4'(k), 100);
      send_key(12, 0, 200);
      send_key(12, 0, 300);
      send_key(12, 0, 600);
      send_key(53, 15, 32'hfffffff0);
      send_key(53, 15, 32'h00000100);
      send_key(4, 3, 5000);
      send_key(4, 3, 9500);
      send_key(11, 3, 9600);
      write_csr(CSR_MASK, 16'hffff);
      send_key(0, 2, 1);
      drive_req(3, 0, 0, 0, 8'h50, 1);
      write_csr(CSR_MASK, 16'h00f0);
      write_csr(CSR_HZ, 16'd4);
      random_phase(50);
      write_csr(CSR_HZ, 16'hffff);
      write_csr(CSR_MASK, 16'h8001);
      random_phase(50);
      write_csr(CSR_HZ, 16'd1000);
      write_csr(CSR_MASK, 16'h0000);
      random_phase(60);
      calm = 1;
      random_phase(20);
      req_valid <= 0;
      @(posedge clock);
      while (pending_events != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

endmodule

@@ files.f @@
rtl/rpkd_pkg.sv
rtl/rpkd_front.sv
rtl/rpkd_queue.sv
rtl/rpkd_back.sv
rtl/remote_packet_key_decoder_unit.sv
tb/sv/rpkd_checker.sv
tb/sv/tb_remote_packet_key_decoder_unit.sv
